>>> rtl/bitplane_int4_dot_product_core_defines.svh
// assertion helpers for the bit-plane dot product core
`ifndef BITPLANE_INT4_DOT_PRODUCT_CORE_DEFINES_SVH
`define BITPLANE_INT4_DOT_PRODUCT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BPDP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpdp same-cycle check failed");

// next-cycle implication, disabled during reset
`define BPDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpdp next-cycle check failed");

`endif

>>> rtl/bpdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpdp_pkg;

  // width of one bit-plane word and of the running total
  localparam int WORD_W = 64;

  // lane products summed per group in the first merge stage
  localparam int GROUP_SIZE = 8;

  typedef logic [WORD_W-1:0] word_t;

endpackage

`default_nettype wire

>>> rtl/bitplane_int4_dot_product_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bitplane_int4_dot_product_core_defines.svh"

// bit-plane dot product core: every input word carries one block of LANES unsigned
// PLANES-bit elements of two vectors, as PLANES bit-plane words of A followed by PLANES
// bit-plane words of B (plane 0 of A in the lowest 64 bits of s_tdata). bits of a plane
// above LANES are ignored. each block's dot product is added to a 64-bit running total;
// a word with s_tlast high closes the vector: the total including that block comes out
// as one signed word on m_tdata and the total is cleared. blocks without s_tlast give no
// output. the total wraps modulo 2^64. one block is accepted every cycle; a result word
// is valid once its closing block has passed each register: the lane products load on the
// accepting edge, then the group sums, then the accumulator and output register. while a
// result waits on m_tready, blocks that do not close a vector still flow into the total;
// only a second closing block stalls, and the input backs up behind it.
module bitplane_int4_dot_product_core #(
  parameter int PLANES = 4,
  parameter int LANES  = 64
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // a_plane0 .. a_plane(PLANES-1), b_plane0 .. b_plane(PLANES-1), 64 bits each
  input  wire [2*PLANES*bpdp_pkg::WORD_W-1:0]   s_tdata,
  input  wire                                   s_tlast,   // last_block
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // dot_product
  output logic signed [bpdp_pkg::WORD_W-1:0]    m_tdata,
  output logic                                  m_tvalid,
  input  wire                                   m_tready
);

  localparam int WORD_W = bpdp_pkg::WORD_W;
  localparam int PROD_W = 2 * PLANES;
  // sum of LANES products, each below 2^PROD_W
  localparam int TOT_W  = PROD_W + $clog2(LANES);

  // pipeline control
  logic              v1, last1;     // lane product stage
  logic              v2, last2;     // group sum stage
  logic              take1, take2;  // stage hand-offs
  logic              ready2;
  logic              out_free;
  logic              in_acc;

  logic [LANES*PROD_W-1:0] lane_prod;
  logic [TOT_W-1:0]        blk_sum;
  bpdp_pkg::word_t         acc;
  bpdp_pkg::word_t         acc_sum;

  // output register free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  // a closing block needs the output register, others just fold into the total
  assign take2    = v2 && (!last2 || out_free);
  assign ready2   = !v2 || take2;
  assign take1    = v1 && ready2;
  assign s_tready = !v1 || ready2;
  assign in_acc   = s_tvalid && s_tready;

  // one lane per element: gather its bit from every plane
  for (genvar n = 0; n < LANES; n++) begin : g_lane
    logic [PLANES-1:0] a_bits;
    logic [PLANES-1:0] b_bits;

    for (genvar k = 0; k < PLANES; k++) begin : g_bit
      assign a_bits[k] = s_tdata[k*WORD_W + n];
      assign b_bits[k] = s_tdata[(PLANES+k)*WORD_W + n];
    end

    bpdp_lane #(
      .PLANES (PLANES)
    ) u_lane (
      .clk    (clk),
      .load   (in_acc),
      .a_bits (a_bits),
      .b_bits (b_bits),
      .prod   (lane_prod[n*PROD_W +: PROD_W])
    );
  end

  // adder tree across the lanes
  bpdp_merge #(
    .LANES  (LANES),
    .PROD_W (PROD_W),
    .TOT_W  (TOT_W)
  ) u_merge (
    .clk   (clk),
    .load  (take1),
    .prod  (lane_prod),
    .total (blk_sum)
  );

  assign acc_sum = acc + {{(WORD_W-TOT_W){1'b0}}, blk_sum};

  // stage valid flags and last markers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      last1 <= 1'b0;
      last2 <= 1'b0;
    end else begin
      if (s_tready) begin
        v1    <= s_tvalid;
        last1 <= s_tlast;
      end
      if (ready2) begin
        v2    <= v1;
        last2 <= last1;
      end
    end
  end

  // running total and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take2) begin
        acc <= last2 ? '0 : acc_sum;
      end
      if (take2 && last2) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take2 && last2) begin
      m_tdata <= signed'(acc_sum);
    end
  end

  // a closing block leaves a cleared total and a pending output
  `BPDP_ASSERT_NEXT(a_close_clears, clk, rst, take2 && last2, m_tvalid && acc == '0)
  // the group stage only holds a closing block blocked by a waiting result
  `BPDP_ASSERT_IMPL(a_stall_cause, clk, rst, v2 && !take2, last2 && m_tvalid && !m_tready)
  // every new output word comes from a closing block
  `BPDP_ASSERT_IMPL(a_out_source, clk, rst, $rose(m_tvalid), $past(take2 && last2))

endmodule

`default_nettype wire

>>> rtl/bpdp_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module bpdp_lane #(
  parameter int PLANES = 4
) (
  input  wire                  clk,
  input  wire                  load,
  input  wire [PLANES-1:0]     a_bits,
  input  wire [PLANES-1:0]     b_bits,
  output logic [2*PLANES-1:0]  prod
);

  localparam int PROD_W = 2 * PLANES;

  logic [PROD_W-1:0] prod_next;

  // shift-and-add over the b planes: each set b bit adds a shifted by its plane
  always_comb begin
    prod_next = '0;
    for (int i = 0; i < PLANES; i++) begin
      if (b_bits[i]) begin
        prod_next = prod_next + (PROD_W'(a_bits) << i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpdp_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module bpdp_merge #(
  parameter int LANES  = 64,
  parameter int PROD_W = 8,
  parameter int TOT_W  = 14
) (
  input  wire                     clk,
  input  wire                     load,
  input  wire [LANES*PROD_W-1:0]  prod,
  output logic [TOT_W-1:0]        total
);

  localparam int GS    = bpdp_pkg::GROUP_SIZE;
  localparam int NGRP  = (LANES + GS - 1) / GS;
  localparam int GRP_W = PROD_W + $clog2(GS);

  logic [GRP_W-1:0] grp      [NGRP];
  logic [GRP_W-1:0] grp_next [NGRP];

  // first level: partial sums of up to eight lanes each
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < LANES) begin
          grp_next[g] = grp_next[g] + GRP_W'(prod[(g*GS+k)*PROD_W +: PROD_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_next;
    end
  end

  // second level: fold the registered group sums
  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + TOT_W'(grp[g]);
    end
  end

endmodule

`default_nettype wire
